// ===== rtl/wiep_pkg.sv =====
// ----------------------------------------------------------------------------
// wiep_pkg
// Types and constants shared by the information element parser modules.
// ----------------------------------------------------------------------------
package wiep_pkg;

  typedef struct packed {
    logic [7:0]  ie_byte;
    logic [11:0] bytes_left;
  } wiep_in_t;

  typedef struct packed {
    logic [4:0]  record_kind;
    logic [7:0]  element_id;
    logic [23:0] value_a;
    logic [15:0] value_b;
    logic [15:0] value_c;
    logic        final_record;
  } wiep_rec_t;

  typedef enum logic [3:0] {
    PH_ID   = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_SKIP = 4'b1000
  } wiep_phase_t;

  typedef struct packed {
    wiep_phase_t phase;
    logic [7:0]  cur_id;
    logic [7:0]  cur_len;
    logic [7:0]  body_idx;
    logic [31:0] held;
    logic [1:0]  trip;
    logic [1:0]  end_status;
  } wiep_state_t;

  localparam logic [4:0] KIND_SSID_START = 5'd0;
  localparam logic [4:0] KIND_SSID_BYTE  = 5'd1;
  localparam logic [4:0] KIND_RATE       = 5'd2;
  localparam logic [4:0] KIND_HT         = 5'd3;
  localparam logic [4:0] KIND_VHT        = 5'd4;
  localparam logic [4:0] KIND_CHAN       = 5'd5;
  localparam logic [4:0] KIND_TIM        = 5'd6;
  localparam logic [4:0] KIND_ATIM       = 5'd7;
  localparam logic [4:0] KIND_COUNTRY    = 5'd8;
  localparam logic [4:0] KIND_TRIPLET    = 5'd9;
  localparam logic [4:0] KIND_LOAD       = 5'd10;
  localparam logic [4:0] KIND_POWER      = 5'd11;
  localparam logic [4:0] KIND_TPC        = 5'd12;
  localparam logic [4:0] KIND_ERP        = 5'd13;
  localparam logic [4:0] KIND_RSN_VER    = 5'd14;
  localparam logic [4:0] KIND_RSN_CIPHER = 5'd15;
  localparam logic [4:0] KIND_END        = 5'd16;

  localparam logic [7:0] EID_SSID    = 8'd0;
  localparam logic [7:0] EID_RATES   = 8'd1;
  localparam logic [7:0] EID_DS      = 8'd3;
  localparam logic [7:0] EID_TIM     = 8'd5;
  localparam logic [7:0] EID_IBSS    = 8'd6;
  localparam logic [7:0] EID_COUNTRY = 8'd7;
  localparam logic [7:0] EID_LOAD    = 8'd11;
  localparam logic [7:0] EID_POWER   = 8'd32;
  localparam logic [7:0] EID_TPC     = 8'd35;
  localparam logic [7:0] EID_ERP     = 8'd42;
  localparam logic [7:0] EID_RSN     = 8'd48;

  localparam logic [6:0] SEL_HT  = 7'h7f;
  localparam logic [6:0] SEL_VHT = 7'h7e;

  localparam logic [1:0] END_OK    = 2'd0;
  localparam logic [1:0] END_TRUNC = 2'd1;
  localparam logic [1:0] END_STRAY = 2'd2;

  localparam wiep_state_t STATE_RESET = '{
    phase: PH_ID, cur_id: 8'd0, cur_len: 8'd0, body_idx: 8'd0,
    held: 32'd0, trip: 2'd0, end_status: END_OK
  };

endpackage

// ===== rtl/wiep_decode.sv =====
// ----------------------------------------------------------------------------
// wiep_decode
// Per-byte element walker: next parser state and up to two records.
// ----------------------------------------------------------------------------
module wiep_decode #(
  parameter int MAX_BLOB_BYTES = 2048
) (
  input  wiep_pkg::wiep_state_t st,
  input  wiep_pkg::wiep_in_t    in_item,
  output wiep_pkg::wiep_state_t st_nxt,
  output logic                  rec_a_vld,
  output wiep_pkg::wiep_rec_t   rec_a,
  output logic                  rec_b_vld,
  output wiep_pkg::wiep_rec_t   rec_b
);
  import wiep_pkg::*;

  localparam logic [16:0] MaxLeft = 17'(MAX_BLOB_BYTES);

  logic [11:0] left0;
  logic [11:0] left;
  logic        last;
  logic [7:0]  v;
  logic [7:0]  h0, h1, h2, h3;
  logic [1:0]  status;

  function automatic wiep_rec_t mk_rec(logic [4:0] kind, logic [7:0] id, logic [23:0] a,
                                       logic [15:0] b, logic [15:0] c);
    wiep_rec_t r;
    r.record_kind  = kind;
    r.element_id   = id;
    r.value_a      = a;
    r.value_b      = b;
    r.value_c      = c;
    r.final_record = 1'b0;
    return r;
  endfunction

  always_comb begin
    v     = in_item.ie_byte;
    left0 = (in_item.bytes_left == 12'd0) ? 12'd1 : in_item.bytes_left;
    left  = ({5'd0, left0} > MaxLeft) ? MaxLeft[11:0] : left0;
    last  = (left == 12'd1);
    h0    = st.held[7:0];
    h1    = st.held[15:8];
    h2    = st.held[23:16];
    h3    = st.held[31:24];

    st_nxt    = st;
    rec_a_vld = 1'b0;
    rec_a     = '0;
    rec_b_vld = 1'b0;
    rec_b     = '0;
    status    = END_OK;

    unique case (st.phase)
      PH_ID: begin
        st_nxt.cur_id   = v;
        st_nxt.cur_len  = 8'd0;
        st_nxt.body_idx = 8'd0;
        st_nxt.held     = 32'd0;
        st_nxt.trip     = 2'd0;
        if (last) begin
          st_nxt.end_status = END_STRAY;
        end else begin
          st_nxt.phase = PH_LEN;
        end
      end
      PH_LEN: begin
        st_nxt.cur_len = v;
        // The body must fit in the bytes that follow the length byte.
        if ({4'd0, v} > left - 12'd1) begin
          st_nxt.end_status = END_TRUNC;
          st_nxt.phase      = PH_SKIP;
        end else begin
          if (st.cur_id == EID_SSID) begin
            rec_a_vld = 1'b1;
            rec_a     = mk_rec(KIND_SSID_START, st.cur_id, {16'd0, v}, 16'd0, 16'd0);
          end
          st_nxt.phase = (v != 8'd0) ? PH_BODY : PH_ID;
        end
      end
      PH_BODY: begin
        unique case (st.cur_id)
          EID_SSID: begin
            rec_a_vld = 1'b1;
            rec_a     = mk_rec(KIND_SSID_BYTE, st.cur_id, {16'd0, v}, 16'd0, 16'd0);
          end
          EID_RATES: begin
            rec_a_vld = 1'b1;
            if (v[7] && v[6:0] == SEL_VHT) begin
              rec_a = mk_rec(KIND_VHT, st.cur_id, {17'd0, SEL_VHT}, 16'd0, 16'd0);
            end else if (v[7] && v[6:0] == SEL_HT) begin
              rec_a = mk_rec(KIND_HT, st.cur_id, {17'd0, SEL_HT}, 16'd0, 16'd0);
            end else begin
              rec_a = mk_rec(KIND_RATE, st.cur_id, {17'd0, v[6:0]}, {15'd0, v[7]}, 16'd0);
            end
          end
          EID_DS: begin
            if (st.body_idx == 8'd0) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_CHAN, st.cur_id, {16'd0, v}, 16'd0, 16'd0);
            end
          end
          EID_TIM: begin
            if (st.body_idx == 8'd1) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_TIM, st.cur_id, {16'd0, h0}, {8'd0, v}, 16'd0);
            end
          end
          EID_IBSS: begin
            if (st.body_idx == 8'd1) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_ATIM, st.cur_id, {8'd0, v, h0}, 16'd0, 16'd0);
            end
          end
          EID_COUNTRY: begin
            if (st.body_idx == 8'd2) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_COUNTRY, st.cur_id, {8'd0, h1, h0}, {8'd0, v}, 16'd0);
            end else if (st.body_idx >= 8'd3) begin
              // Every third byte after the header closes one triplet.
              if (st.trip >= 2'd2) begin
                rec_a_vld      = 1'b1;
                rec_a          = mk_rec(KIND_TRIPLET, st.cur_id, {16'd0, h1}, {8'd0, h0},
                                        {8'd0, v});
                st_nxt.trip = 2'd0;
              end else begin
                st_nxt.trip = st.trip + 2'd1;
              end
            end
          end
          EID_LOAD: begin
            if (st.body_idx == 8'd4) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_LOAD, st.cur_id, {8'd0, h2, h3}, {8'd0, h1}, {v, h0});
            end
          end
          EID_POWER: begin
            if (st.body_idx == 8'd0) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_POWER, st.cur_id, {16'd0, v}, 16'd0, 16'd0);
            end
          end
          EID_TPC: begin
            if (st.body_idx == 8'd1) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_TPC, st.cur_id, {16'd0, h0}, {8'd0, v}, 16'd0);
            end
          end
          EID_ERP: begin
            if (st.body_idx == 8'd0) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_ERP, st.cur_id, {21'd0, v[2:0]}, 16'd0, 16'd0);
            end
          end
          EID_RSN: begin
            if (st.body_idx == 8'd1) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_RSN_VER, st.cur_id, {8'd0, v, h0}, 16'd0, 16'd0);
            end else if (st.body_idx == 8'd5) begin
              rec_a_vld = 1'b1;
              rec_a     = mk_rec(KIND_RSN_CIPHER, st.cur_id, st.held[23:0], {8'd0, v}, 16'd0);
            end
          end
          default: begin
          end
        endcase
        st_nxt.held     = {st.held[23:0], v};
        st_nxt.body_idx = st.body_idx + 8'd1;
        if (st_nxt.body_idx >= st.cur_len) begin
          st_nxt.phase = PH_ID;
        end
      end
      PH_SKIP: begin
      end
      default: begin
        st_nxt.phase = PH_ID;
      end
    endcase

    if (last) begin
      // A blob that stops inside an element body counts as truncated.
      if (st_nxt.phase == PH_BODY && st_nxt.end_status == END_OK) begin
        status = END_TRUNC;
      end else begin
        status = st_nxt.end_status;
      end
      rec_b_vld          = 1'b1;
      rec_b              = mk_rec(KIND_END, 8'd0, {22'd0, status}, 16'd0, 16'd0);
      rec_b.final_record = 1'b1;
      st_nxt             = STATE_RESET;
    end
  end

endmodule

// ===== rtl/wiep_fifo.sv =====
// ----------------------------------------------------------------------------
// wiep_fifo
// Four-entry record queue that takes up to two records per cycle.
// ----------------------------------------------------------------------------
module wiep_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_a,
  input  wiep_pkg::wiep_rec_t rec_a,
  input  logic                push_b,
  input  wiep_pkg::wiep_rec_t rec_b,
  input  logic                pop,
  output logic                rd_vld,
  output wiep_pkg::wiep_rec_t rd_rec,
  output logic                room2
);
  import wiep_pkg::*;

  wiep_rec_t  mem_r [4];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] b_idx;

  always_comb begin
    b_idx     = tail_r + {1'b0, push_a};
    tail_nxt  = tail_r + {1'b0, push_a} + {1'b0, push_b};
    head_nxt  = head_r + {1'b0, pop};
    count_nxt = count_r + {2'd0, push_a} + {2'd0, push_b} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 2'd0;
      tail_r  <= 2'd0;
      count_r <= 3'd0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[tail_r] <= rec_a;
    end
    if (push_b) begin
      mem_r[b_idx] <= rec_b;
    end
  end

  assign rd_vld = (count_r != 3'd0);
  assign rd_rec = mem_r[head_r];
  assign room2  = (count_r <= 3'd2);

endmodule

// ===== rtl/wifi_info_element_parser_unit.sv =====
// ----------------------------------------------------------------------------
// wifi_info_element_parser_unit
// Walks an 802.11 information element blob byte by byte and emits records.
// ----------------------------------------------------------------------------
// Input channel: one blob byte per request with the count of bytes left in
// the blob, this one included; a count of 1 marks the last byte.
// Output channel: one decoded record per request. Each byte gives at most
// one element record, and the last byte of a blob adds an end record with
// the blob status and final_record set.
// The result queue registers each record when its byte is taken.
// Throughput: one byte per cycle while in_stall is low. The result queue
// holds four records, so the last byte of a blob, which may give two
// records, does not hold up the input while the queue drains.
// in_stall is high while fewer than two queue slots are free; it follows
// out_stall only through the queue fill, never combinationally.
// Reset (rst_n low at a clock edge) empties the queue and returns the
// parser to waiting for an element id. A stalled output record holds.
// ----------------------------------------------------------------------------
module wifi_info_element_parser_unit #(
  parameter int MAX_BLOB_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wiep_pkg::wiep_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wiep_pkg::wiep_rec_t out_data
);
  import wiep_pkg::*;

  wiep_state_t st_r, st_nxt;
  logic        in_acc;
  logic        rec_a_vld, rec_b_vld;
  wiep_rec_t   rec_a, rec_b;
  logic        room2;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = !room2;

  wiep_decode #(
    .MAX_BLOB_BYTES(MAX_BLOB_BYTES)
  ) u_decode (
    .st        (st_r),
    .in_item   (in_data),
    .st_nxt    (st_nxt),
    .rec_a_vld (rec_a_vld),
    .rec_a     (rec_a),
    .rec_b_vld (rec_b_vld),
    .rec_b     (rec_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  wiep_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_a (in_acc && rec_a_vld),
    .rec_a  (rec_a),
    .push_b (in_acc && rec_b_vld),
    .rec_b  (rec_b),
    .pop    (out_valid && !out_stall),
    .rd_vld (out_valid),
    .rd_rec (out_data),
    .room2  (room2)
  );

endmodule
